[rtl/core/x86_mov_instruction_decoder_macros.svh]
// Assertion macros shared by the MOV decoder RTL.
`ifndef X86_MOV_INSTRUCTION_DECODER_MACROS_SVH
`define X86_MOV_INSTRUCTION_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define XMD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define XMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/xmd_pkg.sv]
// Types and opcode constants of the MOV decoder.
package xmd_pkg;

    localparam logic [5:0] MOV_RM_OP  = 6'b100010;
    localparam logic [3:0] MOV_IMM_OP = 4'b1011;
    localparam logic [2:0] RM_DIRECT  = 3'b110;
    localparam logic [1:0] MOD_NONE   = 2'b00;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_DIRECT  = 2'd2
    } t_status;

    // Role of a byte within its instruction.
    typedef enum logic [1:0] {
        KIND_OPCODE = 2'd0,
        KIND_MODRM  = 2'd1,
        KIND_LOW    = 2'd2,
        KIND_HIGH   = 2'd3
    } t_kind;

    // Classified byte passed from front to back.
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       emit;
        t_status    status;
    } t_word;

    typedef struct packed {
        logic       form;
        logic       to_register;
        logic       wide;
        logic [1:0] mode_bits;
        logic [2:0] reg_code;
        logic [2:0] rm_code;
        logic [15:0] value;
        t_status    status;
    } t_result;

endpackage

[rtl/core/x86_mov_instruction_decoder.sv]
// Top level of the streaming 8086 MOV instruction decoder.
// Decodes a machine-code byte stream, one byte per word on the input channel, into
// MOV instructions of two forms: register/memory to or from register (100010dw, mod/reg/rm,
// then 0, 1 or 2 displacement bytes) and immediate to register (1011wreg, then 1 or 2 data
// bytes). One result word leaves on the byte that completes an instruction; bytes in the
// middle of an instruction produce nothing. Data values are little-endian and an 8-bit value
// is zero-extended. An opcode byte of neither form yields a status-unknown result with all
// other fields zero; mod 00 with rm 110 (direct address) yields a status-direct result on the
// mod/reg/rm byte, and decoding restarts at the next byte in both cases. The block takes one
// byte every cycle while the queue has room: the front classifier tags each byte in the cycle
// it is accepted, a small queue (QUEUE_DEPTH words) carries the tags, and the back assembler
// builds the result into an output register, so either side may stall without stopping the
// other until the queue fills.
module x86_mov_instruction_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_code_byte,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_form,
    output logic        o_to_register,
    output logic        o_wide,
    output logic [1:0]  o_mode_bits,
    output logic [2:0]  o_reg_code,
    output logic [2:0]  o_rm_code,
    output logic [15:0] o_value,
    output logic [1:0]  o_status
);

    logic           queue_ready;
    logic           push;
    xmd_pkg::t_word push_word;
    logic           queue_valid;
    xmd_pkg::t_word queue_word;
    logic           back_ready;
    xmd_pkg::t_result result;

    // front: phase tracking and byte tagging
    xmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_code_byte   (i_code_byte),
        .i_queue_ready (queue_ready),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_word        (push_word)
    );

    // tagged-byte queue decouples the two halves
    xmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .o_ready     (queue_ready),
        .o_valid     (queue_valid),
        .o_word      (queue_word),
        .i_pop       (queue_valid && back_ready)
    );

    // back: field assembly and output register
    xmd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_word   (queue_word),
        .o_ready  (back_ready),
        .o_valid  (o_valid),
        .o_result (result),
        .i_ready  (i_ready)
    );

    assign o_form        = result.form;
    assign o_to_register = result.to_register;
    assign o_wide        = result.wide;
    assign o_mode_bits   = result.mode_bits;
    assign o_reg_code    = result.reg_code;
    assign o_rm_code     = result.rm_code;
    assign o_value       = result.value;
    assign o_status      = result.status;

endmodule

[rtl/core/xmd_fifo.sv]
// Small register queue between front and back.
module xmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xmd_pkg::t_word i_push_word,
    output logic          o_ready,
    output logic          o_valid,
    output xmd_pkg::t_word o_word,
    input  logic          i_pop
);
    `include "x86_mov_instruction_decoder_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xmd_pkg::t_word r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    `XMD_ASSERT_IMPL(a_no_overflow, i_push, o_ready || i_pop, "queue push while full")
    `XMD_ASSERT_IMPL(a_no_underflow, i_pop, o_valid, "queue pop while empty")
    `XMD_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1,
        "queue count did not grow on push")

endmodule

[rtl/core/xmd_front.sv]
// Byte classifier: tracks instruction phase and tags each byte.
module xmd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_code_byte,
    input  logic           i_queue_ready,
    output logic           o_ready,
    output logic           o_push,
    output xmd_pkg::t_word o_word
);
    typedef enum logic [3:0] {
        PH_OPCODE = 4'b0001,
        PH_MODRM  = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_HIGH   = 4'b1000
    } t_phase;

    t_phase r_phase, n_phase;
    logic   r_two_left, n_two_left;   // a high data byte follows the low one

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

    always_comb begin
        n_phase       = r_phase;
        n_two_left    = r_two_left;
        o_word.data   = i_code_byte;
        o_word.kind   = xmd_pkg::KIND_OPCODE;
        o_word.emit   = 1'b0;
        o_word.status = xmd_pkg::ST_OK;
        unique case (r_phase)
            PH_MODRM: begin
                o_word.kind = xmd_pkg::KIND_MODRM;
                if (i_code_byte[7:6] == xmd_pkg::MOD_NONE &&
                    i_code_byte[2:0] == xmd_pkg::RM_DIRECT) begin
                    o_word.emit   = 1'b1;
                    o_word.status = xmd_pkg::ST_DIRECT;
                    n_phase       = PH_OPCODE;
                end else if (i_code_byte[7:6] == xmd_pkg::MOD_NONE ||
                             i_code_byte[7:6] == xmd_pkg::MOD_REG) begin
                    o_word.emit = 1'b1;
                    n_phase     = PH_OPCODE;
                end else begin
                    n_two_left = (i_code_byte[7:6] == xmd_pkg::MOD_DISP16);
                    n_phase    = PH_LOW;
                end
            end
            PH_LOW: begin
                o_word.kind = xmd_pkg::KIND_LOW;
                if (r_two_left) begin
                    n_phase = PH_HIGH;
                end else begin
                    o_word.emit = 1'b1;
                    n_phase     = PH_OPCODE;
                end
            end
            PH_HIGH: begin
                o_word.kind = xmd_pkg::KIND_HIGH;
                o_word.emit = 1'b1;
                n_phase     = PH_OPCODE;
            end
            default: begin
                // opcode position
                if (i_code_byte[7:2] == xmd_pkg::MOV_RM_OP) begin
                    n_phase = PH_MODRM;
                end else if (i_code_byte[7:4] == xmd_pkg::MOV_IMM_OP) begin
                    n_two_left = i_code_byte[3];
                    n_phase    = PH_LOW;
                end else begin
                    o_word.emit   = 1'b1;
                    o_word.status = xmd_pkg::ST_UNKNOWN;
                    n_phase       = PH_OPCODE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPCODE;
            r_two_left <= 1'b0;
        end else if (o_push) begin
            r_phase    <= n_phase;
            r_two_left <= n_two_left;
        end
    end

endmodule

[rtl/core/xmd_back.sv]
// Instruction assembler: keeps opcode/modrm/low bytes, builds the result word.
module xmd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  xmd_pkg::t_word  i_word,
    output logic            o_ready,
    output logic            o_valid,
    output xmd_pkg::t_result o_result,
    input  logic            i_ready
);
    `include "x86_mov_instruction_decoder_macros.svh"

    logic [7:0] r_opcode;
    logic [7:0] r_modrm;
    logic [7:0] r_low;
    logic       r_valid;
    xmd_pkg::t_result r_res, n_res;

    logic       take;
    logic [7:0] modrm_src;

    assign o_ready  = !r_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    assign modrm_src = (i_word.kind == xmd_pkg::KIND_MODRM) ? i_word.data : r_modrm;

    always_comb begin
        n_res        = '0;
        n_res.status = i_word.status;
        if (i_word.status != xmd_pkg::ST_UNKNOWN) begin
            if (r_opcode[7:4] == xmd_pkg::MOV_IMM_OP) begin
                n_res.form        = 1'b1;
                n_res.to_register = 1'b1;
                n_res.wide        = r_opcode[3];
                n_res.reg_code    = r_opcode[2:0];
            end else begin
                n_res.to_register = r_opcode[1];
                n_res.wide        = r_opcode[0];
                n_res.mode_bits   = modrm_src[7:6];
                n_res.reg_code    = modrm_src[5:3];
                n_res.rm_code     = modrm_src[2:0];
            end
            unique case (i_word.kind)
                xmd_pkg::KIND_LOW:  n_res.value = {8'h00, i_word.data};
                xmd_pkg::KIND_HIGH: n_res.value = {i_word.data, r_low};
                default:            n_res.value = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_opcode <= '0;
            r_modrm  <= '0;
            r_low    <= '0;
        end else begin
            if (take && i_word.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (take) begin
                unique case (i_word.kind)
                    xmd_pkg::KIND_OPCODE: begin
                        if (!i_word.emit) begin
                            r_opcode <= i_word.data;
                        end
                    end
                    xmd_pkg::KIND_MODRM: r_modrm <= i_word.data;
                    xmd_pkg::KIND_LOW:   r_low   <= i_word.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_word.emit) begin
            r_res <= n_res;
        end
    end

    `XMD_ASSERT_IMPL(a_unknown_zero,
        r_valid && r_res.status == xmd_pkg::ST_UNKNOWN,
        !r_res.form && r_res.value == '0 && r_res.reg_code == '0,
        "unknown opcode result carries fields")
    `XMD_ASSERT_IMPL(a_direct_fields,
        r_valid && r_res.status == xmd_pkg::ST_DIRECT,
        !r_res.form && r_res.mode_bits == xmd_pkg::MOD_NONE &&
        r_res.rm_code == xmd_pkg::RM_DIRECT && r_res.value == '0,
        "direct address result malformed")
    `XMD_ASSERT_IMPL(a_imm_fields, r_valid && r_res.form,
        r_res.to_register && r_res.mode_bits == '0 && r_res.rm_code == '0,
        "immediate result malformed")

endmodule

[tb/sv/mov_decode_checker.sv]
// Checker for the MOV decoder: predicts results from accepted code bytes and compares them.
module mov_decode_checker
    import xmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_code_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_form,
    input  logic        i_to_register,
    input  logic        i_wide,
    input  logic [1:0]  i_mode_bits,
    input  logic [2:0]  i_reg_code,
    input  logic [2:0]  i_rm_code,
    input  logic [15:0] i_value,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_unknown,
    output int          o_direct
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        WAIT_OPCODE,
        WAIT_MODRM,
        WAIT_LOW,
        WAIT_HIGH
    } t_decode_phase;

    t_decode_phase decode_phase;
    logic [7:0]    opcode_q;
    logic [7:0]    modrm_q;
    logic [7:0]    low_q;
    logic [1:0]    bytes_owed;
    t_result       results_due[$];

    // Instruction done: build the result from the held opcode and mod/reg/rm bytes.
    task automatic complete_instr(input logic [15:0] value, input t_status status);
        t_result r;
        r = '0;
        if (opcode_q[7:4] == MOV_IMM_OP) begin
            r.form        = 1'b1;
            r.to_register = 1'b1;
            r.wide        = opcode_q[3];
            r.reg_code    = opcode_q[2:0];
        end else begin
            r.to_register = opcode_q[1];
            r.wide        = opcode_q[0];
            r.mode_bits   = modrm_q[7:6];
            r.reg_code    = modrm_q[5:3];
            r.rm_code     = modrm_q[2:0];
        end
        r.value      = value;
        r.status     = status;
        decode_phase = WAIT_OPCODE;
        bytes_owed   = 2'd0;
        results_due.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        case (decode_phase)
            WAIT_OPCODE: begin
                if (b[7:2] == MOV_RM_OP) begin
                    opcode_q     = b;
                    decode_phase = WAIT_MODRM;
                end else if (b[7:4] == MOV_IMM_OP) begin
                    opcode_q     = b;
                    bytes_owed   = b[3] ? 2'd2 : 2'd1;
                    decode_phase = WAIT_LOW;
                end else begin
                    bytes_owed = 2'd0;
                    r.status   = ST_UNKNOWN;
                    results_due.push_back(r);
                end
            end
            WAIT_MODRM: begin
                modrm_q = b;
                if (b[7:6] == MOD_NONE && b[2:0] == RM_DIRECT) begin
                    complete_instr(16'h0000, ST_DIRECT);
                end else if (b[7:6] == MOD_NONE || b[7:6] == MOD_REG) begin
                    complete_instr(16'h0000, ST_OK);
                end else begin
                    bytes_owed   = b[7:6];
                    decode_phase = WAIT_LOW;
                end
            end
            WAIT_LOW: begin
                low_q = b;
                if (bytes_owed >= 2'd2) begin
                    bytes_owed   = 2'd1;
                    decode_phase = WAIT_HIGH;
                end else begin
                    complete_instr({8'h00, b}, ST_OK);
                end
            end
            default: complete_instr({b, low_q}, ST_OK);
        endcase
    endtask

    task automatic check_field(input string field, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field,
                     expected, actual);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_unknown    = 0;
        o_direct     = 0;
    end

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            decode_phase = WAIT_OPCODE;
            opcode_q     = 8'h00;
            modrm_q      = 8'h00;
            low_q        = 8'h00;
            bytes_owed   = 2'd0;
            results_due.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decode_byte(i_code_byte);
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (i_status == ST_UNKNOWN)
                    o_unknown++;
                if (i_status == ST_DIRECT)
                    o_direct++;
                if (results_due.size() == 0) begin
                    $display("%0t ns: result word with none expected (status %0d)",
                             $time, i_status);
                    o_fail_count++;
                end else begin
                    due = results_due.pop_front();
                    check_field("form", due.form, i_form);
                    check_field("to_register", due.to_register, i_to_register);
                    check_field("wide", due.wide, i_wide);
                    check_field("mode_bits", due.mode_bits, i_mode_bits);
                    check_field("reg_code", due.reg_code, i_reg_code);
                    check_field("rm_code", due.rm_code, i_rm_code);
                    check_field("value", due.value, i_value);
                    check_field("status", due.status, i_status);
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

[tb/sv/tb_x86_mov_instruction_decoder.sv]
// Testbench top for the MOV decoder: byte stimulus, output flow control and verdict.
module tb_x86_mov_instruction_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import xmd_pkg::*;

    // mod 01: one displacement byte (not in the package)
    localparam logic [1:0] MOD_DISP8 = 2'b01;
    localparam int RANDOM_BYTES     = 1850;
    // final stretch of bytes sent with both sides running flat out
    localparam int QUIET_TAIL       = 150;
    // long output hold-off so the internal queue fills and input stalls
    localparam int HOLD_CYCLES      = 80;
    // cycles without any accepted word before the run is declared hung
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_code_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_form;
    logic        o_to_register;
    logic        o_wide;
    logic [1:0]  o_mode_bits;
    logic [2:0]  o_reg_code;
    logic [2:0]  o_rm_code;
    logic [15:0] o_value;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int results_seen;
    int unknown_seen;
    int direct_seen;
    int bytes_sent;
    int stuck_cycles;

    // shared between stimulus and the output-side process
    logic idle_on;
    logic hold_req;
    logic hold_done;

    x86_mov_instruction_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_byte   (i_code_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_form        (o_form),
        .o_to_register (o_to_register),
        .o_wide        (o_wide),
        .o_mode_bits   (o_mode_bits),
        .o_reg_code    (o_reg_code),
        .o_rm_code     (o_rm_code),
        .o_value       (o_value),
        .o_status      (o_status)
    );

    mov_decode_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_code_byte   (i_code_byte),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_form        (o_form),
        .i_to_register (o_to_register),
        .i_wide        (o_wide),
        .i_mode_bits   (o_mode_bits),
        .i_reg_code    (o_reg_code),
        .i_rm_code     (o_rm_code),
        .i_value       (o_value),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results_seen),
        .o_unknown     (unknown_seen),
        .o_direct      (direct_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: any cycle that moves a word on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Output side: random stall bursts while idling is on, plus one long hold-off.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Opcode and mod/reg/rm byte builders.
    function automatic logic [7:0] rm_op(input logic d, input logic w);
        return {MOV_RM_OP, d, w};
    endfunction

    function automatic logic [7:0] imm_op(input logic w, input logic [2:0] reg_no);
        return {MOV_IMM_OP, w, reg_no};
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] reg_no,
                                         input logic [2:0] rm);
        return {md, reg_no, rm};
    endfunction

    // Random data byte, leaning toward the all-zero and all-one extremes.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Entered and left just after a falling edge. Valid stays up across back-to-back words.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_code_byte = b;
        do
            @(posedge i_clk);
        while (!o_ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Register/memory form: displacement bytes follow mod, except for direct address.
    task automatic send_rm(input logic d, input logic w, input logic [1:0] md,
                           input logic [2:0] reg_no, input logic [2:0] rm,
                           input logic [15:0] disp);
        send_byte(rm_op(d, w));
        send_byte(modrm(md, reg_no, rm));
        if (md == MOD_DISP8) begin
            send_byte(disp[7:0]);
        end else if (md == MOD_DISP16) begin
            send_byte(disp[7:0]);
            send_byte(disp[15:8]);
        end
    endtask

    task automatic send_imm(input logic w, input logic [2:0] reg_no, input logic [15:0] data);
        send_byte(imm_op(w, reg_no));
        send_byte(data[7:0]);
        if (w)
            send_byte(data[15:8]);
    endtask

    // One random instruction, or a stray byte now and then.
    task automatic send_random_instr();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            send_rm(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)), {pick_byte(), pick_byte()});
        end else if (sel < 8) begin
            send_imm(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     {pick_byte(), pick_byte()});
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_code_byte = 8'h00;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        bytes_sent  = 0;
        stuck_cycles = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every mod, d/w combinations, field extremes, the direct-address
        // trap, both immediate widths and unknown opcodes.
        send_rm(1'b0, 1'b0, MOD_REG, 3'd0, 3'd1, 16'h0000);
        send_rm(1'b1, 1'b1, MOD_NONE, 3'd7, 3'd7, 16'h0000);
        // rm 110 with a displacement is an ordinary memory operand
        send_rm(1'b1, 1'b0, MOD_DISP8, 3'd0, RM_DIRECT, 16'h00FF);
        send_rm(1'b0, 1'b1, MOD_DISP16, 3'd7, RM_DIRECT, 16'hFFFF);
        // direct address: error on the mod/reg/rm byte, no displacement taken
        send_rm(1'b1, 1'b1, MOD_NONE, 3'd6, RM_DIRECT, 16'h0000);
        send_imm(1'b0, 3'd0, 16'h00FF);
        send_imm(1'b1, 3'd7, 16'hFFFF);
        send_imm(1'b1, 3'd1, 16'h1234);
        send_byte(8'h00);
        send_byte(8'hFF);
        // one step off the register/memory opcode pattern
        send_byte(8'h8C);

        // Random part. Long hold-off first, then alternating stretches with and
        // without idling, and a flat-out tail.
        hold_req = 1'b1;
        while (bytes_sent < RANDOM_BYTES) begin
            if (bytes_sent >= RANDOM_BYTES - QUIET_TAIL)
                idle_on = 1'b0;
            else
                idle_on = ((bytes_sent / 250) % 3) != 2;
            send_random_instr();
        end
        idle_on = 1'b0;
        i_valid = 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d code bytes; checked %0d results, %0d unknown opcode and %0d direct",
                 bytes_sent, results_seen, unknown_seen, direct_seen);
        $display("address, with random stalls on both sides and one long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/xmd_pkg.sv
rtl/core/xmd_fifo.sv
rtl/core/xmd_front.sv
rtl/core/xmd_back.sv
rtl/core/x86_mov_instruction_decoder.sv
tb/sv/mov_decode_checker.sv
tb/sv/tb_x86_mov_instruction_decoder.sv
